// ----- rtl/core/glc_pkg.sv -----
// Shared types, constants and sizes for the glyph slot cache.
package glc_pkg;

  localparam int SLOTS    = 256;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int CODE_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 9;
  localparam int OUT_W    = 8;
  localparam int OC_W     = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(256);
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST    = CFG_W'(16);

  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic REG_ROW_WIDTH    = 1'b1;

  typedef enum logic [OC_W-1:0] {
    OUT_HIT    = 2'd0,
    OUT_PLACED = 2'd1,
    OUT_NONE   = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic div_step;
    logic out_load;
  } glc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_free;
  } glc_status_t;

endpackage

// ----- rtl/core/glc_req_if.sv -----
// Request channel: character code and frame stamp with valid/ready.
interface glc_req_if;
  import glc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic [STAMP_W-1:0] frame_now;

  modport source (output valid, output char_code, output frame_now, input ready);
  modport sink   (input valid, input char_code, input frame_now, output ready);
endinterface

// ----- rtl/core/glc_rsp_if.sv -----
// Response channel: lookup outcome and slot position with valid/ready.
interface glc_rsp_if;
  import glc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OC_W-1:0]  outcome;
  logic [OUT_W-1:0] slot_column;
  logic [OUT_W-1:0] slot_row;
  logic [OUT_W-1:0] slot_index;

  modport source (output valid, output outcome, output slot_column, output slot_row,
                  output slot_index, input ready);
  modport sink   (input valid, input outcome, input slot_column, input slot_row,
                  input slot_index, output ready);
endinterface

// ----- rtl/core/glc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/glc_regs.sv -----
// APB configuration registers: managed slot count and grid row width.
module glc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [glc_pkg::ADDR_W-1:0]    paddr,
  input  logic [glc_pkg::DATA_W-1:0]    pwdata,
  output logic [glc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [glc_pkg::CFG_W-1:0]     slots_in_use,
  output logic [glc_pkg::CFG_W-1:0]     row_width
);
  import glc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
      row_width    <= ROW_WIDTH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SLOTS_IN_USE: slots_in_use <= pwdata[CFG_W-1:0];
        REG_ROW_WIDTH:    row_width    <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOTS_IN_USE: prdata = DATA_W'(slots_in_use);
      REG_ROW_WIDTH:    prdata = DATA_W'(row_width);
    endcase
  end

endmodule

// ----- rtl/core/glc_ctrl.sv -----
// Controller state machine that sequences scan, update, divide and output.
module glc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  glc_pkg::glc_status_t  status,
  output glc_pkg::glc_cmd_t     cmd
);
  import glc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t state;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.load     = req_valid;
      ST_SCAN:   cmd.scan     = 1'b1;
      ST_COMMIT: cmd.commit   = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_HOLD:   cmd.out_load = status.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (req_valid) state <= ST_SCAN;
        ST_SCAN:   if (status.scan_done) state <= ST_COMMIT;
        ST_COMMIT: state <= ST_DIV;
        ST_DIV:    if (status.div_done) state <= ST_HOLD;
        ST_HOLD:   if (status.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/glc_dpath.sv -----
// Datapath: slot memory, scan trackers, restoring divider and output register.
module glc_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  glc_pkg::glc_cmd_t            cmd,
  output glc_pkg::glc_status_t         status,
  input  logic [glc_pkg::CODE_W-1:0]   char_code,
  input  logic [glc_pkg::STAMP_W-1:0]  frame_now,
  input  logic [glc_pkg::CFG_W-1:0]    slots_in_use,
  input  logic [glc_pkg::CFG_W-1:0]    row_width,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [glc_pkg::OC_W-1:0]     outcome,
  output logic [glc_pkg::OUT_W-1:0]    slot_column,
  output logic [glc_pkg::OUT_W-1:0]    slot_row,
  output logic [glc_pkg::OUT_W-1:0]    slot_index
);
  import glc_pkg::*;

  // Request and configuration captured at load.
  logic [CODE_W-1:0]  code_q;
  logic [STAMP_W-1:0] now_q;
  logic [CNT_W-1:0]   n_q;
  logic [CFG_W-1:0]   rw_q;

  // Scan pipeline.
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_live;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_vld;
  logic               ram_re;
  slot_t              ram_rdata;
  logic [SLOTS-1:0]   vld;

  // Trackers.
  logic               hit_found, empty_found, old_found;
  logic [IDX_W-1:0]   hit_idx, empty_idx, old_idx;
  logic [STAMP_W-1:0] oldest;

  logic [CODE_W-1:0]  cur_code;
  logic [STAMP_W-1:0] cur_stamp;

  // Decision.
  outcome_t           pick_oc;
  logic [IDX_W-1:0]   pick_idx;
  logic               ram_we;
  slot_t              ram_wdata;
  outcome_t           oc_q;
  logic [IDX_W-1:0]   idx_q;

  // Divider.
  localparam int DIV_CW = $clog2(IDX_W + 1);
  logic [DIV_CW-1:0]  div_cnt;
  logic [IDX_W-1:0]   quo_q;
  logic [CFG_W-1:0]   rem_q;
  logic [CFG_W:0]     rem_sh;
  logic [CFG_W:0]     rem_diff;

  assign ram_re    = cmd.scan && (issue_cnt != n_q);
  assign cur_code  = rd_vld ? ram_rdata.code  : '0;
  assign cur_stamp = rd_vld ? ram_rdata.stamp : '0;

  assign status.scan_done = (issue_cnt == n_q) && !rd_live;
  assign status.div_done  = (div_cnt == '0);
  assign status.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    priority if (hit_found) begin
      pick_oc  = OUT_HIT;
      pick_idx = hit_idx;
    end else if (empty_found) begin
      pick_oc  = OUT_PLACED;
      pick_idx = empty_idx;
    end else if (old_found) begin
      pick_oc  = OUT_PLACED;
      pick_idx = old_idx;
    end else begin
      pick_oc  = OUT_NONE;
      pick_idx = '0;
    end
  end

  // A hit rewrites the same code with the new stamp, so one write form serves both.
  assign ram_we          = cmd.commit && (pick_oc != OUT_NONE);
  assign ram_wdata.code  = code_q;
  assign ram_wdata.stamp = now_q;

  assign rem_sh   = {rem_q, quo_q[IDX_W-1]};
  assign rem_diff = rem_sh - {1'b0, rw_q};

  glc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rd_live   <= 1'b0;
      issue_cnt <= '0;
      n_q       <= '0;
      div_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        code_q      <= char_code;
        now_q       <= frame_now;
        rw_q        <= (row_width == '0) ? CFG_W'(1) : row_width;
        // Code zero is never stored, so it scans nothing and gets no slot.
        if (char_code == '0) begin
          n_q <= '0;
        end else if (int'(slots_in_use) > SLOTS) begin
          n_q <= CNT_W'(SLOTS);
        end else begin
          n_q <= CNT_W'(slots_in_use);
        end
        issue_cnt   <= '0;
        rd_live     <= 1'b0;
        hit_found   <= 1'b0;
        empty_found <= 1'b0;
        old_found   <= 1'b0;
        oldest      <= frame_now;
      end

      if (cmd.scan) begin
        rd_live <= ram_re;
        if (ram_re) begin
          issue_cnt <= issue_cnt + CNT_W'(1);
          rd_idx    <= issue_cnt[IDX_W-1:0];
          rd_vld    <= vld[issue_cnt[IDX_W-1:0]];
        end
        if (rd_live) begin
          if (!hit_found && (cur_code == code_q)) begin
            hit_found <= 1'b1;
            hit_idx   <= rd_idx;
          end
          if (!empty_found && (cur_code == '0)) begin
            empty_found <= 1'b1;
            empty_idx   <= rd_idx;
          end
          // Strictly older wins, so the first slot of a tie is kept.
          if (cur_stamp < oldest) begin
            oldest    <= cur_stamp;
            old_found <= 1'b1;
            old_idx   <= rd_idx;
          end
        end
      end

      if (cmd.commit) begin
        if (ram_we) begin
          vld[pick_idx] <= 1'b1;
        end
        oc_q    <= pick_oc;
        idx_q   <= pick_idx;
        quo_q   <= pick_idx;
        rem_q   <= '0;
        div_cnt <= DIV_CW'(IDX_W);
      end

      if (cmd.div_step && (div_cnt != '0)) begin
        div_cnt <= div_cnt - DIV_CW'(1);
        if (!rem_diff[CFG_W]) begin
          rem_q <= rem_diff[CFG_W-1:0];
          quo_q <= (quo_q << 1) | IDX_W'(1);
        end else begin
          rem_q <= rem_sh[CFG_W-1:0];
          quo_q <= quo_q << 1;
        end
      end

      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
        outcome   <= oc_q;
        if (oc_q == OUT_NONE) begin
          slot_column <= '0;
          slot_row    <= '0;
          slot_index  <= '0;
        end else begin
          slot_column <= OUT_W'(rem_q);
          slot_row    <= OUT_W'(quo_q);
          slot_index  <= OUT_W'(idx_q);
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/glyph_slot_lru_cache.sv -----
// Top level of the glyph slot cache: channels, configuration and submodules.
//
// A request transaction on req carries a character code and the current frame
// number. The block searches the managed slots for the code, then for the first
// empty slot, then for the slot with the oldest stamp older than the frame, and
// answers on rsp with the outcome (hit, placed, no slot) and the slot's index,
// column and row in a grid of row_width slots per row.
// The single read port of the slot memory is swept one entry per cycle, then the row
// and column come from a restoring divider that retires one quotient bit per cycle.
// The response sits in an output register; the next request is accepted as soon
// as the previous one has been handed to that register, even if rsp is stalled.
// A finished response waits for the output register while rsp stays stalled.
// Reset empties every slot at once through per-slot valid bits, with no clearing
// pass, and sets slots_in_use to 256 and row_width to 16.
// The user must write the APB registers only while no request is in flight; the block does not enforce it.
module glyph_slot_lru_cache (
  input  logic                        clk,
  input  logic                        rst,
  glc_req_if.sink                     req,
  glc_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [glc_pkg::ADDR_W-1:0]  paddr,
  input  logic [glc_pkg::DATA_W-1:0]  pwdata,
  output logic [glc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import glc_pkg::*;

  glc_cmd_t          cmd;
  glc_status_t       status;
  logic [CFG_W-1:0]  slots_in_use;
  logic [CFG_W-1:0]  row_width;

  glc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slots_in_use (slots_in_use),
    .row_width    (row_width)
  );

  glc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  glc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .char_code    (req.char_code),
    .frame_now    (req.frame_now),
    .slots_in_use (slots_in_use),
    .row_width    (row_width),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .outcome      (rsp.outcome),
    .slot_column  (rsp.slot_column),
    .slot_row     (rsp.slot_row),
    .slot_index   (rsp.slot_index)
  );

endmodule

// ----- bench/glyph_slot_lru_cache_test.sv -----
// Self-checking testbench for the glyph slot cache: predicts every lookup and checks each response.
module glyph_slot_lru_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glc_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [ADDR_W-1:0] ADDR_SLOTS_IN_USE = ADDR_W'(4 * int'(REG_SLOTS_IN_USE));
  localparam logic [ADDR_W-1:0] ADDR_ROW_WIDTH    = ADDR_W'(4 * int'(REG_ROW_WIDTH));

  typedef struct packed {
    outcome_t         outcome;
    logic [OUT_W-1:0] column;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] index;
  } slot_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  glc_req_if req_ch ();
  glc_rsp_if rsp_ch ();

  glyph_slot_lru_cache u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the slot table and the two registers.
  logic [CODE_W-1:0]  glyph_code  [SLOTS];
  logic [STAMP_W-1:0] glyph_stamp [SLOTS];
  logic [CFG_W-1:0]   managed_slots;
  logic [CFG_W-1:0]   grid_width;

  slot_answer_t       pending_answers [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  bit                 steady = 1'b0;
  logic [STAMP_W-1:0] frame_clock = '0;

  always #1 clk = ~clk;

  function automatic slot_answer_t lookup_glyph(logic [CODE_W-1:0] code,
                                                logic [STAMP_W-1:0] now);
    slot_answer_t       ans;
    int                 n;
    int                 rw;
    int                 pick;
    logic [STAMP_W-1:0] oldest;
    ans = '{OUT_NONE, '0, '0, '0};
    if (code == '0) return ans;
    n = (managed_slots > SLOTS) ? SLOTS : int'(managed_slots);
    rw = (grid_width == '0) ? 1 : int'(grid_width);
    pick = -1;
    for (int i = 0; i < n; i++) begin
      if (glyph_code[i] == code) begin
        pick = i;
        break;
      end
    end
    if (pick >= 0) begin
      glyph_stamp[pick] = now;
      ans.outcome = OUT_HIT;
    end else begin
      for (int i = 0; i < n && pick < 0; i++) begin
        if (glyph_code[i] == '0) pick = i;
      end
      // With no empty slot, only a stamp strictly older than now may be replaced.
      if (pick < 0) begin
        oldest = now;
        for (int i = 0; i < n; i++) begin
          if (glyph_stamp[i] < oldest) begin
            oldest = glyph_stamp[i];
            pick = i;
          end
        end
      end
      if (pick < 0) return ans;
      glyph_code[pick] = code;
      glyph_stamp[pick] = now;
      ans.outcome = OUT_PLACED;
    end
    ans.column = OUT_W'(pick % rw);
    ans.row    = OUT_W'(pick / rw);
    ans.index  = OUT_W'(pick);
    return ans;
  endfunction

  task automatic send_request(logic [CODE_W-1:0] code, logic [STAMP_W-1:0] now);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.char_code <= code;
    req_ch.frame_now <= now;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_answers.push_back(lookup_glyph(code, now));
  endtask

  task automatic wait_for_answers();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic reg_sel, logic [CFG_W-1:0] value,
                                logic [DATA_W-CFG_W-1:0] upper);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (reg_sel == REG_ROW_WIDTH) ? ADDR_ROW_WIDTH : ADDR_SLOTS_IN_USE;
    pwdata  <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_SLOTS_IN_USE) managed_slots = value;
    else grid_width = value;
  endtask

  // Registers change only once every outstanding transaction has been answered.
  task automatic configure(logic [CFG_W-1:0] slots, logic [CFG_W-1:0] width, bit noisy);
    wait_for_answers();
    write_register(REG_SLOTS_IN_USE, slots, noisy ? (DATA_W-CFG_W)'($urandom) : '0);
    write_register(REG_ROW_WIDTH, width, noisy ? (DATA_W-CFG_W)'($urandom) : '0);
  endtask

  task automatic check_answer();
    slot_answer_t want;
    if (pending_answers.size() == 0) begin
      $error("response with no request waiting: outcome %0d, slot_index %0d",
             rsp_ch.outcome, rsp_ch.slot_index);
      mismatches++;
      return;
    end
    want = pending_answers.pop_front();
    if (rsp_ch.outcome !== want.outcome) begin
      $error("outcome mismatch: expected %0d, actual %0d", want.outcome, rsp_ch.outcome);
      mismatches++;
    end
    if (rsp_ch.slot_column !== want.column) begin
      $error("slot_column mismatch: expected %0d, actual %0d", want.column, rsp_ch.slot_column);
      mismatches++;
    end
    if (rsp_ch.slot_row !== want.row) begin
      $error("slot_row mismatch: expected %0d, actual %0d", want.row, rsp_ch.slot_row);
      mismatches++;
    end
    if (rsp_ch.slot_index !== want.index) begin
      $error("slot_index mismatch: expected %0d, actual %0d", want.index, rsp_ch.slot_index);
      mismatches++;
    end
  endtask

  function automatic logic [STAMP_W-1:0] pick_frame();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) frame_clock = frame_clock + STAMP_W'($urandom_range(1, 3));
    if (roll >= 95) return STAMP_W'($urandom);
    if (roll >= 88) return frame_clock - STAMP_W'($urandom_range(1, 8));
    return frame_clock;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(logic [CODE_W-1:0] base, int pool);
    int                roll;
    logic [CODE_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 7) return CODE_W'($urandom);
    c = base + CODE_W'($urandom_range(0, pool - 1));
    return (c == '0) ? CODE_W'(1) : c;
  endfunction

  // Codes come from a small pool so hits, evictions and full frames all recur.
  task automatic run_random_phase(int count, logic [CFG_W-1:0] slots,
                                  logic [CFG_W-1:0] width, int pool);
    logic [CODE_W-1:0] base;
    configure(slots, width, 1'b1);
    base = CODE_W'($urandom);
    frame_clock = STAMP_W'($urandom);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (k == count / 2) wait_for_answers();
      send_request(pick_code(base, pool), pick_frame());
    end
    steady = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_request(16'h0000, 32'h0000_0000);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    send_request(16'h0001, 32'h0000_0000);
    send_request(16'hFFFF, 32'h0000_0005);
    send_request(16'h8000, 32'h7FFF_FFFF);
    send_request(16'h0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_grid_extremes();
    configure(9'd256, 9'd256, 1'b0);
    send_request(16'h0101, 32'h0000_0001);
    // A row width of zero behaves as one slot per row.
    configure(9'd256, 9'd0, 1'b0);
    send_request(16'h0202, 32'h0000_0001);
    configure(9'd256, 9'd3, 1'b0);
    send_request(16'h0202, 32'h0000_0002);
  endtask

  task automatic test_eviction_order();
    configure(9'd3, 9'd2, 1'b0);
    send_request(16'h0303, 32'd100);
    send_request(16'h0001, 32'd100);
    send_request(16'h0404, 32'd100);
    send_request(16'h0505, 32'd101);
    send_request(16'h0606, 32'd101);
    send_request(16'h0707, 32'd101);
    send_request(16'h8000, 32'd3);
    send_request(16'h0808, 32'd4);
  endtask

  task automatic test_no_managed_slots();
    configure(9'd0, 9'd1, 1'b0);
    send_request(16'h0505, 32'd200);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_count_regrowth();
    configure(9'd3, 9'd16, 1'b0);
    send_request(16'h0202, 32'd300);
    // A count above the table depth saturates; the lowest matching slot must win.
    configure(9'h1FF, 9'd16, 1'b0);
    send_request(16'h0202, 32'd301);
    send_request(16'h0101, 32'd301);
  endtask

  task automatic test_random_small_tables();
    logic [CFG_W-1:0] slots;
    logic [CFG_W-1:0] width;
    for (int p = 0; p < 12; p++) begin
      if (p == 0) slots = 9'd1;
      else if (p % 4 == 3) slots = CFG_W'($urandom_range(17, 64));
      else slots = CFG_W'($urandom_range(1, 16));
      if ($urandom_range(0, 1)) width = CFG_W'($urandom_range(1, 256));
      else width = CFG_W'($urandom_range(1, int'(slots)));
      run_random_phase(120, slots, width, int'(slots) + $urandom_range(1, int'(slots) + 2));
    end
  endtask

  task automatic test_random_full_table();
    run_random_phase(450, 9'd256, 9'd1, 600);
  endtask

  always @(posedge clk) begin
    if (rst || ((req_ch.valid & req_ch.ready) === 1'b1) ||
        ((rsp_ch.valid & rsp_ch.ready) === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** glyph_slot_lru_cache: FAILED **");
    $finish;
  end

  initial begin : answer_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      check_answer();
    end
  end

  initial begin : sequencer
    req_ch.valid     <= 1'b0;
    req_ch.char_code <= '0;
    req_ch.frame_now <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      glyph_code[i]  = '0;
      glyph_stamp[i] = '0;
    end
    managed_slots = SLOTS_IN_USE_RST;
    grid_width    = ROW_WIDTH_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_grid_extremes();
    test_eviction_order();
    test_no_managed_slots();
    test_count_regrowth();
    test_random_small_tables();
    test_random_full_table();

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected responses never arrived", pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** glyph_slot_lru_cache: PASSED **");
    end else begin
      $display("** glyph_slot_lru_cache: FAILED **");
    end
    $finish;
  end

endmodule
